FILE: src/running_binary_gcd_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the running binary GCD block
// Short forms for the concurrent checks used by the port checker.
// ---------------------------------------------------------------------------
`ifndef RUNNING_BINARY_GCD_TOP_ASSERT_SVH
`define RUNNING_BINARY_GCD_TOP_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define RBG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("running_binary_gcd check failed");

// Next-cycle implication, quiet during reset.
`define RBG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("running_binary_gcd check failed");

// Next-cycle implication that also holds across reset.
`define RBG_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("running_binary_gcd check failed");

`endif

FILE: src/rbg_pkg.sv
// ---------------------------------------------------------------------------
// Running binary GCD package
// Widths, sequencer states and the control structs shared by the modules.
// ---------------------------------------------------------------------------
package rbg_pkg;

  localparam int VALUE_WIDTH = 31;
  localparam int TWOS_W      = $clog2(VALUE_WIDTH);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [TWOS_W-1:0]      twos_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STRIP,
    ST_REDUCE,
    ST_DONE
  } rbg_state_t;

  typedef struct packed {
    logic start;
    logic ack;
  } core_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

endpackage

FILE: src/rbg_core.sv
// ---------------------------------------------------------------------------
// Binary GCD iteration unit
// One compare/subtract/shift step per cycle under a small sequencer.
// ---------------------------------------------------------------------------
module rbg_core (
  input  logic                clk,
  input  logic                rst_n,
  input  rbg_pkg::core_ctrl_t ctrl,
  input  rbg_pkg::value_t     op_a,
  input  rbg_pkg::value_t     op_b,
  output rbg_pkg::core_stat_t stat,
  output rbg_pkg::value_t     result
);

  rbg_pkg::rbg_state_t state_r, state_nxt;
  rbg_pkg::value_t     a_r, a_nxt;
  rbg_pkg::value_t     b_r, b_nxt;
  rbg_pkg::twos_t      twos_r, twos_nxt;

  logic            a_lt_b;
  rbg_pkg::value_t lo_val;
  rbg_pkg::value_t hi_val;

  assign a_lt_b = (a_r < b_r);
  assign lo_val = a_lt_b ? a_r : b_r;
  assign hi_val = a_lt_b ? b_r : a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rbg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    twos_r <= twos_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    twos_nxt  = twos_r;
    case (state_r)
      rbg_pkg::ST_IDLE: begin
        if (ctrl.start) begin
          a_nxt     = op_a;
          b_nxt     = op_b;
          twos_nxt  = '0;
          state_nxt = rbg_pkg::ST_STRIP;
        end
      end
      rbg_pkg::ST_STRIP: begin
        // gcd(0, x) = x
        if ((a_r == '0) || (b_r == '0)) begin
          a_nxt     = a_r | b_r;
          state_nxt = rbg_pkg::ST_DONE;
        end else if (!a_r[0] && !b_r[0]) begin
          a_nxt    = {1'b0, a_r[rbg_pkg::VALUE_WIDTH-1:1]};
          b_nxt    = {1'b0, b_r[rbg_pkg::VALUE_WIDTH-1:1]};
          twos_nxt = twos_r + rbg_pkg::TWOS_W'(1);
        end else begin
          state_nxt = rbg_pkg::ST_REDUCE;
        end
      end
      rbg_pkg::ST_REDUCE: begin
        if (!a_r[0]) begin
          a_nxt = {1'b0, a_r[rbg_pkg::VALUE_WIDTH-1:1]};
        end else if (!b_r[0]) begin
          b_nxt = {1'b0, b_r[rbg_pkg::VALUE_WIDTH-1:1]};
        end else if (a_r == b_r) begin
          state_nxt = rbg_pkg::ST_DONE;
        end else begin
          a_nxt = lo_val;
          b_nxt = hi_val - lo_val;
        end
      end
      rbg_pkg::ST_DONE: begin
        if (ctrl.ack) begin
          state_nxt = rbg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rbg_pkg::ST_IDLE;
      end
    endcase
  end

  assign stat.busy = (state_r != rbg_pkg::ST_IDLE);
  assign stat.done = (state_r == rbg_pkg::ST_DONE);
  assign result    = a_r << twos_r;

endmodule

FILE: src/running_binary_gcd_top.sv
// ---------------------------------------------------------------------------
// Running binary GCD
// Folds each block size into a running GCD (Stein's method) and reports the
// GCD together with a flag that stays set while the GCD has not changed.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  in_     | into      | in_valid/in_stall  | block_size[30:0], first_item
//  out_    | out of    | out_valid/out_stall| gcd_value[30:0], gcd_unchanged
//
//  A transfer in starts rbg_core, which goes straight to done when either
//  operand is zero, else strips the shared twos, then halves and subtracts
//  until the operands match (a subtract is always followed by a halving).
//  The result then goes to the output register. in_stall is high meanwhile.
//  The output register holds a stalled result; a new item may still be taken,
//  its result waiting in the unit until the slot frees. Reset clears the GCD.
// ---------------------------------------------------------------------------
module running_binary_gcd_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rbg_pkg::VALUE_WIDTH-1:0]     in_block_size,
  input  logic                                in_first_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rbg_pkg::VALUE_WIDTH-1:0]     out_gcd_value,
  output logic                                out_gcd_unchanged
);

  rbg_pkg::core_ctrl_t ctrl;
  rbg_pkg::core_stat_t stat;
  rbg_pkg::value_t     core_result;
  rbg_pkg::value_t     op_a;

  // running state of the current set
  rbg_pkg::value_t gcd_r, gcd_nxt;
  logic            flag_r, flag_nxt;
  logic            first_r, first_nxt;

  // output register
  logic            out_valid_r, out_valid_nxt;
  rbg_pkg::value_t out_gcd_r, out_gcd_nxt;
  logic            out_flag_r, out_flag_nxt;

  logic in_xfer;
  logic load;
  logic flag_new;

  // take an item only while the unit is free
  assign in_stall = stat.busy;
  assign in_xfer  = in_valid && !in_stall;

  // a new set starts the fold from zero
  assign op_a = in_first_item ? '0 : gcd_r;

  // move a finished result into the output slot once it is empty or draining
  assign load = stat.done && (!out_valid_r || !out_stall);

  assign ctrl.start = in_xfer;
  assign ctrl.ack   = load;

  // the first item of a set never clears the flag
  assign flag_new = flag_r && (first_r || (core_result == gcd_r));

  rbg_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .op_a   (op_a),
    .op_b   (in_block_size),
    .stat   (stat),
    .result (core_result)
  );

  always_comb begin
    gcd_nxt       = gcd_r;
    flag_nxt      = flag_r;
    first_nxt     = first_r;
    out_gcd_nxt   = out_gcd_r;
    out_flag_nxt  = out_flag_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (in_xfer) begin
      first_nxt = in_first_item;
      if (in_first_item) begin
        gcd_nxt  = '0;
        flag_nxt = 1'b1;
      end
    end
    if (load) begin
      gcd_nxt       = core_result;
      flag_nxt      = flag_new;
      out_gcd_nxt   = core_result;
      out_flag_nxt  = flag_new;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gcd_r       <= '0;
      flag_r      <= 1'b1;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      gcd_r       <= gcd_nxt;
      flag_r      <= flag_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_gcd_r  <= out_gcd_nxt;
    out_flag_r <= out_flag_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_gcd_value     = out_gcd_r;
  assign out_gcd_unchanged = out_flag_r;

endmodule

FILE: src/rbg_checker.sv
// ---------------------------------------------------------------------------
// Running binary GCD port checker
// Watches the top level's ports over time; bound to every instance.
// ---------------------------------------------------------------------------
`include "running_binary_gcd_top_assert.svh"

module rbg_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [rbg_pkg::VALUE_WIDTH-1:0] out_gcd_value,
  input logic                            out_gcd_unchanged
);

  // hold a stalled result
  `RBG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `RBG_ASSERT_NEXT(a_gcd_stable, clk, rst_n, out_valid && out_stall, $stable(out_gcd_value))
  `RBG_ASSERT_NEXT(a_flag_stable, clk, rst_n, out_valid && out_stall, $stable(out_gcd_unchanged))
  // the unit is busy right after a transfer in
  `RBG_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && !in_stall, in_stall)
  // drop any result on reset
  `RBG_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid && !in_stall)

endmodule

bind running_binary_gcd_top rbg_checker u_rbg_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_gcd_value     (out_gcd_value),
  .out_gcd_unchanged (out_gcd_unchanged)
);

FILE: tb/sv/running_binary_gcd_top_tb.sv
// ---------------------------------------------------------------------------
// Running binary GCD testbench
// Sends block sizes through the input channel, both as a short table of
// directed items and as random sets. Each transfer is run through a local
// GCD predictor, and every result transfer is checked field by field
// against the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module running_binary_gcd_top_tb;

  localparam int   IDLE_PCT     = 34;
  localparam int   RANDOM_ITEMS = 750;
  localparam int   CALM_FROM    = 300;      // transfer count where idling stops
  localparam int   CALM_TO      = 420;      // ... and where it resumes
  localparam int   DRAIN_CYCLES = 2 * rbg_pkg::VALUE_WIDTH + 16;
  localparam int   CYCLE_LIMIT  = 400000;
  localparam rbg_pkg::value_t ALL_ONES = {rbg_pkg::VALUE_WIDTH{1'b1}};

  // One row of the directed table. Where 'typed' is set, the expected result
  // is taken from the row; otherwise the predictor supplies it.
  typedef struct packed {
    rbg_pkg::value_t size;
    logic            first;
    logic            typed;
    rbg_pkg::value_t gcd;
    logic            steady;
  } opening_row_t;

  typedef struct packed {
    rbg_pkg::value_t gcd;
    logic            steady;
  } gcd_result_t;

  localparam int N_OPENING = 21;

  opening_row_t opening_rows [N_OPENING] = '{
    // No opening mark after reset: the set is taken to start at reset.
    '{31'd0,          1'b0, 1'b1, 31'd0,          1'b1},
    '{31'd12,         1'b0, 1'b1, 31'd12,         1'b0},
    // Largest size opens a set; zero leaves it alone.
    '{31'h7FFF_FFFF,  1'b1, 1'b1, 31'h7FFF_FFFF,  1'b1},
    '{31'd0,          1'b0, 1'b1, 31'h7FFF_FFFF,  1'b1},
    '{31'h7FFF_FFFF,  1'b0, 1'b1, 31'h7FFF_FFFF,  1'b1},
    '{31'h4000_0000,  1'b0, 1'b1, 31'd1,          1'b0},
    // A set opening with zeros reports zero until its first nonzero size.
    '{31'd0,          1'b1, 1'b1, 31'd0,          1'b1},
    '{31'd0,          1'b0, 1'b1, 31'd0,          1'b1},
    '{31'h4000_0000,  1'b0, 1'b1, 31'h4000_0000,  1'b0},
    '{31'h2000_0000,  1'b0, 1'b1, 31'h2000_0000,  1'b0},
    '{31'd1,          1'b1, 1'b1, 31'd1,          1'b1},
    '{31'h7FFF_FFFE,  1'b0, 1'b1, 31'd1,          1'b1},
    // Ordinary sets, left to the predictor.
    '{31'd48,         1'b1, 1'b0, 31'd0,          1'b0},
    '{31'd18,         1'b0, 1'b0, 31'd0,          1'b0},
    '{31'd30,         1'b0, 1'b0, 31'd0,          1'b0},
    '{31'd96,         1'b1, 1'b0, 31'd0,          1'b0},
    '{31'd64,         1'b0, 1'b0, 31'd0,          1'b0},
    '{31'h7FFF_FFE0,  1'b0, 1'b0, 31'd0,          1'b0},
    '{31'h5555_5555,  1'b1, 1'b0, 31'd0,          1'b0},
    '{31'h2AAA_AAAA,  1'b0, 1'b0, 31'd0,          1'b0},
    '{31'h7FFF_FFFF,  1'b0, 1'b0, 31'd0,          1'b0}
  };

  logic            clk               = 1'b0;
  logic            rst_n             = 1'b0;
  logic            in_valid          = 1'b0;
  logic            in_stall;
  rbg_pkg::value_t in_block_size     = '0;
  logic            in_first_item     = 1'b0;
  logic            out_valid;
  logic            out_stall         = 1'b0;
  rbg_pkg::value_t out_gcd_value;
  logic            out_gcd_unchanged;

  // Predictor state: mirrors the running GCD and the unchanged flag.
  rbg_pkg::value_t set_gcd    = '0;
  logic            set_steady = 1'b1;
  gcd_result_t     gcd_due_q [$];

  int  mismatches = 0;
  int  transfers  = 0;
  int  cycle_count = 0;
  bit  calm       = 1'b0;

  running_binary_gcd_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_block_size     (in_block_size),
    .in_first_item     (in_first_item),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_gcd_value     (out_gcd_value),
    .out_gcd_unchanged (out_gcd_unchanged)
  );

  always #1 clk = ~clk;

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // Stein's method: strip shared twos, make the first operand odd, then
  // repeatedly halve the other and subtract the smaller odd value.
  function automatic rbg_pkg::value_t stein_gcd(rbg_pkg::value_t a, rbg_pkg::value_t b);
    int              twos = 0;
    rbg_pkg::value_t t;
    if (a == '0) return b;
    if (b == '0) return a;
    while (a[0] == 1'b0 && b[0] == 1'b0) begin
      a = a >> 1;
      b = b >> 1;
      twos++;
    end
    while (a[0] == 1'b0) a = a >> 1;
    do begin
      while (b[0] == 1'b0) b = b >> 1;
      if (a > b) begin
        t = a;
        a = b;
        b = t;
      end
      b = b - a;
    end while (b != '0);
    return a << twos;
  endfunction

  // Fold one accepted size into the predicted set state and return the result.
  function automatic gcd_result_t fold_size(rbg_pkg::value_t size, logic first);
    gcd_result_t     r;
    rbg_pkg::value_t prev;
    if (first) begin
      set_gcd    = '0;
      set_steady = 1'b1;
    end
    prev       = set_gcd;
    set_gcd    = stein_gcd(prev, size);
    set_steady = set_steady && (first || set_gcd == prev);
    r.gcd      = set_gcd;
    r.steady   = set_steady;
    return r;
  endfunction

  // Offer one item, hold it until the transfer, then log its expectation.
  // A typed expectation replaces the prediction, but the predictor still
  // advances so later rows stay in step.
  task automatic send_size(rbg_pkg::value_t size, logic first, logic typed,
                           gcd_result_t typed_res);
    gcd_result_t predicted;
    while (take_break()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_block_size <= size;
    in_first_item <= first;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = fold_size(size, first);
    gcd_due_q = {gcd_due_q, (typed ? typed_res : predicted)};
    transfers++;
    calm = (transfers >= CALM_FROM) && (transfers < CALM_TO);
  endtask

  // Mixture of sizes: multiples of the set's base keep the GCD steady for a
  // while, powers of two and zeros hit the shift paths, full-width values
  // exercise every bit.
  function automatic rbg_pkg::value_t pick_size(rbg_pkg::value_t base);
    int unsigned lim;
    case ($urandom_range(9))
      0: return '0;
      1, 2, 3: begin
        lim = 32'h7FFF_FFFF / base;
        return rbg_pkg::value_t'(base * $urandom_range(1, (lim > 4096) ? 4096 : lim));
      end
      4: return rbg_pkg::value_t'(1) << $urandom_range(rbg_pkg::VALUE_WIDTH - 1);
      5: return ALL_ONES ^ (rbg_pkg::value_t'(1) << $urandom_range(rbg_pkg::VALUE_WIDTH - 1));
      6: return rbg_pkg::value_t'($urandom_range(1, 64));
      default: return rbg_pkg::value_t'($urandom);
    endcase
  endfunction

  // Result side: check each transfer, then pick next cycle's stall.
  always @(posedge clk) begin
    gcd_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (gcd_due_q.size() == 0) begin
          $error("unexpected result: gcd_value %0d, gcd_unchanged %0b",
                 out_gcd_value, out_gcd_unchanged);
          mismatches++;
        end else begin
          want = gcd_due_q.pop_front();
          if (out_gcd_value !== want.gcd) begin
            $error("gcd_value: expected %0d, actual %0d", want.gcd, out_gcd_value);
            mismatches++;
          end
          if (out_gcd_unchanged !== want.steady) begin
            $error("gcd_unchanged: expected %0b, actual %0b",
                   want.steady, out_gcd_unchanged);
            mismatches++;
          end
        end
      end
      out_stall <= take_break();
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rbg_pkg::value_t base;
    int              set_len;
    bit              noisy;
    gcd_result_t     typed_res;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table first.
    for (int i = 0; i < N_OPENING; i++) begin
      typed_res.gcd    = opening_rows[i].gcd;
      typed_res.steady = opening_rows[i].steady;
      send_size(opening_rows[i].size, opening_rows[i].first,
                opening_rows[i].typed, typed_res);
    end

    // Random sets: mostly well formed (mark on the first item only), with
    // one set in ten carrying random marks as noise.
    while (transfers < N_OPENING + RANDOM_ITEMS) begin
      base    = rbg_pkg::value_t'($urandom_range(1, 255)) << $urandom_range(0, 12);
      set_len = $urandom_range(1, 10);
      noisy   = ($urandom_range(9) == 0);
      for (int k = 0; k < set_len; k++) begin
        send_size(pick_size(base), noisy ? logic'($urandom_range(1)) : (k == 0),
                  1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    // Drain, then allow for a stray late result.
    while (gcd_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
